### src/emwp_pkg.sv
// Shared types and constants for the ext2 metadata write planner.
// No dependencies; used by the controller, the datapath and the top level.
package emwp_pkg;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SUPER = 2'd1;
  localparam logic [1:0] KIND_DESC  = 2'd2;

  localparam logic [2:0] REG_SPARSE_SUPER   = 3'd0;
  localparam logic [2:0] REG_META_BG_ENABLE = 3'd1;
  localparam logic [2:0] REG_FIRST_META_BG  = 3'd2;
  localparam logic [2:0] REG_LEGACY_DESC    = 3'd3;
  localparam logic [2:0] REG_DESC_LOG2      = 3'd4;
  localparam logic [2:0] REG_FIRST_DATA     = 3'd5;
  localparam logic [2:0] REG_BLOCKS_PER_GRP = 3'd6;
  localparam logic [2:0] REG_WRITE_MODE     = 3'd7;

  localparam logic [15:0] STAMP_MAX = 16'hFFFF;

  // Number of nonzero powers of 3, 5 and 7 that fit in 32 bits.
  localparam int POW3_COUNT = 20;
  localparam int POW5_COUNT = 13;
  localparam int POW7_COUNT = 11;

  typedef struct packed {
    logic load;
    logic plan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // True for groups 0, 1 and every power of 3, 5 or 7.
  function automatic logic sparse_group(input logic [31:0] g);
    logic [63:0] p;
    logic        hit;
    hit = (g == 32'd0) || (g == 32'd1);
    p = 64'd3;
    for (int i = 0; i < POW3_COUNT; i++) begin
      hit = hit || (g == p[31:0]);
      p = p * 64'd3;
    end
    p = 64'd5;
    for (int i = 0; i < POW5_COUNT; i++) begin
      hit = hit || (g == p[31:0]);
      p = p * 64'd5;
    end
    p = 64'd7;
    for (int i = 0; i < POW7_COUNT; i++) begin
      hit = hit || (g == p[31:0]);
      p = p * 64'd7;
    end
    return hit;
  endfunction

endpackage

### src/emwp_ctrl.sv
// Controller for the ext2 metadata write planner: request intake, planning
// and result sequencing. Depends on emwp_pkg.
module emwp_ctrl #(
  parameter int IDX_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  emwp_pkg::status_t  status,
  input  logic [IDX_W-1:0]   run_counter,
  output emwp_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]   idx
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] idx_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.plan   = 1'b1;
        idx_next   = '0;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (idx == run_counter) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

### src/emwp_datapath.sv
// Datapath for the ext2 metadata write planner: configuration registers,
// group address arithmetic, write planning and the result register.
// Depends on emwp_pkg.
module emwp_datapath #(
  parameter int MAX_DESC_BLOCKS = 63,
  parameter int ADDR_WIDTH      = 32,
  parameter int IDX_W           = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [31:0]        group_index,
  input  emwp_pkg::cmd_t     cmd,
  input  logic [IDX_W-1:0]   idx,
  output emwp_pkg::status_t  status,
  output logic [IDX_W-1:0]   run_counter,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         write_kind,
  output logic [31:0]        block_address,
  output logic [26:0]        source_desc_block,
  output logic [15:0]        group_stamp,
  output logic               last
);

  localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_DESC_BLOCKS);

  logic                  sparse_super;
  logic                  meta_bg_enable;
  logic [31:0]           first_meta_bg;
  logic [5:0]            legacy_desc_blocks;
  logic [3:0]            descs_per_block_log2;
  logic [31:0]           first_data_block;
  logic [31:0]           blocks_per_group;
  logic [1:0]            write_mode;

  logic [31:0]           latched_group;
  logic [ADDR_WIDTH-1:0] product;
  logic [ADDR_WIDTH-1:0] group_base_block;
  logic                  backup_sb;
  logic [31:0]           meta_group;
  logic                  mod_first;
  logic                  mod_second;
  logic                  mod_final;

  logic                  n_super;
  logic                  meta_sel;
  logic                  none_run;

  logic [31:0]           mod_mask;
  logic [31:0]           mod_val;
  logic                  master_only;
  logic                  super_only;
  logic                  grp_nonzero;
  logic [IDX_W-1:0]      legacy_cnt;
  logic [IDX_W-1:0]      plan_desc;
  logic                  plan_super;
  logic [IDX_W:0]        plan_total;
  logic [IDX_W-1:0]      desc_j;
  logic [IDX_W:0]        offset;
  logic [ADDR_WIDTH-1:0] addr;
  logic [1:0]            kind_c;
  logic [26:0]           src_c;
  logic [15:0]           stamp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      sparse_super         <= 1'b0;
      meta_bg_enable       <= 1'b0;
      first_meta_bg        <= 32'd0;
      legacy_desc_blocks   <= 6'd1;
      descs_per_block_log2 <= 4'd5;
      first_data_block     <= 32'd1;
      blocks_per_group     <= 32'd8192;
      write_mode           <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emwp_pkg::REG_SPARSE_SUPER:   sparse_super         <= cfg_data[0];
        emwp_pkg::REG_META_BG_ENABLE: meta_bg_enable       <= cfg_data[0];
        emwp_pkg::REG_FIRST_META_BG:  first_meta_bg        <= cfg_data;
        emwp_pkg::REG_LEGACY_DESC:    legacy_desc_blocks   <= cfg_data[5:0];
        emwp_pkg::REG_DESC_LOG2:      descs_per_block_log2 <= cfg_data[3:0];
        emwp_pkg::REG_FIRST_DATA:     first_data_block     <= cfg_data;
        emwp_pkg::REG_BLOCKS_PER_GRP: blocks_per_group     <= cfg_data;
        emwp_pkg::REG_WRITE_MODE:     write_mode           <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign mod_mask    = ~(32'hFFFF_FFFF << descs_per_block_log2);
  assign mod_val     = group_index & mod_mask;
  assign master_only = write_mode[0];
  assign super_only  = write_mode[1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      latched_group <= group_index;
      product       <= ADDR_WIDTH'(64'(group_index) * 64'(blocks_per_group));
      backup_sb     <= !sparse_super || emwp_pkg::sparse_group(group_index);
      meta_group    <= group_index >> descs_per_block_log2;
      mod_first     <= (mod_val == 32'd0);
      mod_second    <= (mod_val == 32'd1);
      mod_final     <= (mod_val == mod_mask);
    end
  end

  assign grp_nonzero = (latched_group != 32'd0);

  always_comb begin
    legacy_cnt = '0;
    if (meta_bg_enable) begin
      legacy_cnt = (first_meta_bg > 32'(MAX_DESC_BLOCKS)) ? MAX_CNT : IDX_W'(first_meta_bg);
    end else begin
      legacy_cnt = (32'(legacy_desc_blocks) > 32'(MAX_DESC_BLOCKS)) ?
                   MAX_CNT : IDX_W'(legacy_desc_blocks);
    end
  end

  always_comb begin
    plan_super = !master_only && grp_nonzero && backup_sb;
    plan_desc  = '0;
    if (!super_only) begin
      if (!meta_bg_enable || (meta_group < first_meta_bg)) begin
        if (backup_sb && !(master_only && grp_nonzero)) begin
          plan_desc = legacy_cnt;
        end
      end else if ((mod_first || mod_second || mod_final) &&
                   !(!mod_first && master_only)) begin
        plan_desc = IDX_W'(1);
      end
    end
    plan_total = (IDX_W + 1)'(plan_super) + (IDX_W + 1)'(plan_desc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_counter <= '0;
    end else if (cmd.plan) begin
      run_counter <= (plan_total == '0) ? '0 : IDX_W'(plan_total - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      group_base_block <= ADDR_WIDTH'(first_data_block) + product;
      n_super          <= plan_super;
      meta_sel         <= meta_bg_enable && !(meta_group < first_meta_bg);
      none_run         <= (plan_total == '0);
    end
  end

  assign desc_j = idx - IDX_W'(n_super);

  always_comb begin
    kind_c  = emwp_pkg::KIND_DESC;
    src_c   = '0;
    stamp_c = '0;
    offset  = '0;
    priority if (none_run) begin
      kind_c = emwp_pkg::KIND_NONE;
    end else if (n_super && (idx == '0)) begin
      kind_c  = emwp_pkg::KIND_SUPER;
      stamp_c = (latched_group > 32'(emwp_pkg::STAMP_MAX)) ?
                emwp_pkg::STAMP_MAX : latched_group[15:0];
    end else if (meta_sel) begin
      offset = (IDX_W + 1)'(backup_sb);
      src_c  = meta_group[26:0];
    end else begin
      offset = (IDX_W + 1)'(desc_j) + 1'b1;
      src_c  = 27'(desc_j);
    end
  end

  assign addr = group_base_block + ADDR_WIDTH'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      write_kind        <= kind_c;
      block_address     <= 32'(addr);
      source_desc_block <= src_c;
      group_stamp       <= stamp_c;
      last              <= (idx == run_counter);
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

### src/ext2_metadata_write_planner.sv
// Ext2 metadata write planner, top level: stream ports and configuration
// port around the emwp_ctrl controller and the emwp_datapath. Depends on emwp_pkg.
//
// Each accepted request carries one block group number and produces a run of
// one to MAX_DESC_BLOCKS + 1 results (backup superblock, then descriptor
// blocks, or a single result of kind none), with tlast on the final one. A
// request is taken in the idle state and planned in the plan state (the group
// base address multiply is registered at intake and added to first_data_block
// while the run length is worked out), and then results leave at one per
// cycle through the output register whenever that register is free. A new
// request is accepted once the last result of the previous run is in the
// output register, even while that result waits to be taken.
module ext2_metadata_write_planner #(
  parameter int MAX_DESC_BLOCKS = 63,
  parameter int ADDR_WIDTH      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] group_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] block_address, [58:32] source_desc_block,
                                 // [74:59] group_stamp, [79:75] zero
  output logic [1:0]  m_tuser,   // [1:0] write_kind
  output logic        m_tlast
);

  localparam int IDX_W = $clog2(MAX_DESC_BLOCKS + 1);

  emwp_pkg::cmd_t    cmd;
  emwp_pkg::status_t status;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  run_counter;
  logic [31:0]       block_address;
  logic [26:0]       source_desc_block;
  logic [15:0]       group_stamp;

  emwp_ctrl #(
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .status      (status),
    .run_counter (run_counter),
    .cmd         (cmd),
    .idx         (idx)
  );

  emwp_datapath #(
    .MAX_DESC_BLOCKS (MAX_DESC_BLOCKS),
    .ADDR_WIDTH      (ADDR_WIDTH),
    .IDX_W           (IDX_W)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .group_index       (s_tdata),
    .cmd               (cmd),
    .idx               (idx),
    .status            (status),
    .run_counter       (run_counter),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .write_kind        (m_tuser),
    .block_address     (block_address),
    .source_desc_block (source_desc_block),
    .group_stamp       (group_stamp),
    .last              (m_tlast)
  );

  assign m_tdata = {5'd0, group_stamp, source_desc_block, block_address};

endmodule
